@@ rtl/core/tts_pkg.sv @@
// Shared constants, codes and control structs for the timed task slot table.
// Used by tts_ctrl, tts_datapath and timed_task_slot_table_top; no dependencies.
package tts_pkg;

  localparam int NUM_SLOTS   = 16;
  localparam int IDX_W       = $clog2(NUM_SLOTS);
  localparam int MAX_HANDLED = 16;
  localparam int HCNT_W      = $clog2(MAX_HANDLED + 1);
  localparam int CD_W        = 20;

  localparam logic [CD_W-1:0] SEC_PER_HOUR = CD_W'(3600);
  localparam logic [CD_W-1:0] SEC_PER_MIN  = CD_W'(60);

  localparam logic [2:0] OP_ADD         = 3'd0;
  localparam logic [2:0] OP_REMOVE      = 3'd1;
  localparam logic [2:0] OP_REMOVE_TYPE = 3'd2;
  localparam logic [2:0] OP_SET_STATUS  = 3'd3;
  localparam logic [2:0] OP_DELAY       = 3'd4;
  localparam logic [2:0] OP_TICK        = 3'd5;

  localparam logic [2:0] ST_FREE    = 3'd0;
  localparam logic [2:0] ST_PENDING = 3'd1;
  localparam logic [2:0] ST_DONE    = 3'd3;
  localparam logic [2:0] ST_FAILED  = 3'd4;

  localparam logic [1:0] TYPE_CALL = 2'd1;

  localparam logic [2:0] RK_ADDED    = 3'd0;
  localparam logic [2:0] RK_FULL     = 3'd1;
  localparam logic [2:0] RK_REMOVED  = 3'd2;
  localparam logic [2:0] RK_WAS_FREE = 3'd3;
  localparam logic [2:0] RK_ACK      = 3'd4;
  localparam logic [2:0] RK_FIRED    = 3'd5;
  localparam logic [2:0] RK_TICK_END = 3'd6;

  localparam logic CFG_CALL_SIM = 1'b0;
  localparam logic CFG_POSTPONE = 1'b1;

  localparam logic [7:0] POSTPONE_RESET = 8'd60;

  typedef struct packed {
    logic capture;
    logic scan_step;
    logic edit_step;
    logic tick_end;
  } ctrl_t;

  typedef struct packed {
    logic new_is_scan;
    logic out_free;
    logic add_stop;
    logic tick_last;
  } stat_t;

endpackage

@@ rtl/core/tts_ctrl.sv @@
// Controller state machine of the timed task slot table.
// Depends on tts_pkg for the command and status structs.
module tts_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  tts_pkg::stat_t stat,
  output tts_pkg::ctrl_t ctrl
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EDIT = 2'd2;
  localparam logic [1:0] S_TEND = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready = (state == S_IDLE) && !rst;

  always_comb begin
    state_next     = state;
    ctrl           = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctrl.capture = 1'b1;
          state_next   = stat.new_is_scan ? S_SCAN : S_EDIT;
        end
      end
      S_SCAN: begin
        if (stat.out_free) begin
          ctrl.scan_step = 1'b1;
          if (stat.add_stop) begin
            state_next = S_IDLE;
          end else if (stat.tick_last) begin
            state_next = S_TEND;
          end
        end
      end
      S_EDIT: begin
        if (stat.out_free) begin
          ctrl.edit_step = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_TEND: begin
        if (stat.out_free) begin
          ctrl.tick_end = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/core/tts_datapath.sv @@
// Datapath of the timed task slot table: slot arrays, scan index, registers
// and the result register. Depends on tts_pkg; driven by tts_ctrl.
module tts_datapath (
  input  logic                clk,
  input  logic                rst,
  input  tts_pkg::ctrl_t      ctrl,
  output tts_pkg::stat_t      stat,
  input  logic                cfg_valid,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_data,
  input  logic [2:0]          op,
  input  logic [3:0]          slot,
  input  logic [1:0]          job_type,
  input  logic                time_mode,
  input  logic [7:0]          hours,
  input  logic [7:0]          minutes,
  input  logic [31:0]         target_time,
  input  logic [31:0]         now_time,
  input  logic [2:0]          new_status,
  input  logic [7:0]          delay_seconds,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          reply_kind,
  output logic [3:0]          slot_index,
  output logic [1:0]          fired_type,
  output logic                last
);

  localparam int N = tts_pkg::NUM_SLOTS;
  localparam int W = tts_pkg::IDX_W;

  logic [2:0]  slot_status [N];
  logic [1:0]  slot_type [N];
  logic [31:0] slot_due_time [N];

  logic                        call_simulation;
  logic [7:0]                  postpone_seconds;

  logic [2:0]                  op_r;
  logic [3:0]                  slot_r;
  logic [1:0]                  jtype_r;
  logic                        mode_r;
  logic [31:0]                 target_r;
  logic [31:0]                 now_r;
  logic [2:0]                  nstat_r;
  logic [7:0]                  dsec_r;
  logic [tts_pkg::CD_W-1:0]    countdown;
  logic [W-1:0]                idx;
  logic [tts_pkg::HCNT_W-1:0]  handled;
  logic [N-1:0]                done_mask;

  logic [2:0]  cur_status;
  logic [1:0]  cur_type;
  logic [31:0] cur_due;
  logic        at_last;
  logic        is_add;
  logic        in_range;
  logic        fire;
  logic        postpone;
  logic        emit;
  logic [2:0]  emit_kind;
  logic [3:0]  emit_index;
  logic [1:0]  emit_type;
  logic        emit_last;

  assign cur_status = slot_status[idx];
  assign cur_type   = slot_type[idx];
  assign cur_due    = slot_due_time[idx];
  assign at_last    = (idx == W'(N - 1));
  assign is_add     = (op_r == tts_pkg::OP_ADD);
  assign in_range   = (32'(slot_r) < 32'(N));
  assign fire       = (cur_status == tts_pkg::ST_PENDING) && (now_r >= cur_due) &&
                      (handled < tts_pkg::HCNT_W'(tts_pkg::MAX_HANDLED));
  assign postpone   = (cur_type == tts_pkg::TYPE_CALL) && call_simulation;

  assign stat.new_is_scan = (op == tts_pkg::OP_ADD) || (op == tts_pkg::OP_TICK);
  assign stat.out_free    = !out_valid || out_ready;
  assign stat.add_stop    = is_add && ((cur_status == tts_pkg::ST_FREE) || at_last);
  assign stat.tick_last   = !is_add && at_last;

  always_comb begin
    emit       = 1'b0;
    emit_kind  = tts_pkg::RK_ACK;
    emit_index = 4'd0;
    emit_type  = 2'd0;
    emit_last  = 1'b1;
    if (ctrl.scan_step) begin
      if (is_add) begin
        if (cur_status == tts_pkg::ST_FREE) begin
          emit       = 1'b1;
          emit_kind  = tts_pkg::RK_ADDED;
          emit_index = 4'(idx);
        end else if (at_last) begin
          emit      = 1'b1;
          emit_kind = tts_pkg::RK_FULL;
        end
      end else if (fire && !postpone) begin
        emit       = 1'b1;
        emit_kind  = tts_pkg::RK_FIRED;
        emit_index = 4'(idx);
        emit_type  = cur_type;
        emit_last  = 1'b0;
      end
    end else if (ctrl.tick_end) begin
      emit      = 1'b1;
      emit_kind = tts_pkg::RK_TICK_END;
    end else if (ctrl.edit_step) begin
      emit = 1'b1;
      if (op_r == tts_pkg::OP_REMOVE) begin
        emit_index = slot_r;
        if (in_range && (cur_status != tts_pkg::ST_FREE)) begin
          emit_kind = tts_pkg::RK_REMOVED;
        end else begin
          emit_kind = tts_pkg::RK_WAS_FREE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      call_simulation  <= 1'b0;
      postpone_seconds <= tts_pkg::POSTPONE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        tts_pkg::CFG_CALL_SIM: call_simulation  <= cfg_data[0];
        tts_pkg::CFG_POSTPONE: postpone_seconds <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      op_r      <= op;
      slot_r    <= slot;
      jtype_r   <= job_type;
      mode_r    <= time_mode;
      target_r  <= target_time;
      now_r     <= now_time;
      nstat_r   <= new_status;
      dsec_r    <= delay_seconds;
      countdown <= tts_pkg::CD_W'(hours) * tts_pkg::SEC_PER_HOUR +
                   tts_pkg::CD_W'(minutes) * tts_pkg::SEC_PER_MIN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      handled   <= '0;
      done_mask <= '0;
    end else if (ctrl.capture) begin
      idx       <= stat.new_is_scan ? '0 : W'(slot);
      handled   <= '0;
      done_mask <= '0;
    end else if (ctrl.scan_step) begin
      idx <= idx + W'(1);
      if (!is_add) begin
        if (fire) begin
          handled <= handled + tts_pkg::HCNT_W'(1);
        end
        done_mask[idx] <= (fire && !postpone) || (cur_status == tts_pkg::ST_DONE) ||
                          (cur_status == tts_pkg::ST_FAILED);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N; i++) begin
        slot_status[i]   <= tts_pkg::ST_FREE;
        slot_type[i]     <= 2'd0;
        slot_due_time[i] <= 32'd0;
      end
    end else if (ctrl.scan_step) begin
      if (is_add) begin
        if (cur_status == tts_pkg::ST_FREE) begin
          slot_status[idx]   <= tts_pkg::ST_PENDING;
          slot_type[idx]     <= jtype_r;
          slot_due_time[idx] <= mode_r ? now_r + 32'(countdown) : target_r;
        end
      end else if (fire) begin
        if (postpone) begin
          slot_due_time[idx] <= cur_due + 32'(postpone_seconds);
        end else begin
          slot_status[idx] <= tts_pkg::ST_DONE;
        end
      end
    end else if (ctrl.tick_end) begin
      if (handled != '0) begin
        for (int i = 0; i < N; i++) begin
          if (done_mask[i]) begin
            slot_status[i] <= tts_pkg::ST_FREE;
            slot_type[i]   <= 2'd0;
          end
        end
      end
    end else if (ctrl.edit_step) begin
      case (op_r)
        tts_pkg::OP_REMOVE: begin
          if (in_range) begin
            slot_status[idx] <= tts_pkg::ST_FREE;
            slot_type[idx]   <= 2'd0;
          end
        end
        tts_pkg::OP_REMOVE_TYPE: begin
          for (int i = 0; i < N; i++) begin
            if (slot_type[i] == jtype_r) begin
              slot_status[i] <= tts_pkg::ST_FREE;
              slot_type[i]   <= 2'd0;
            end
          end
        end
        tts_pkg::OP_SET_STATUS: begin
          if (in_range) begin
            slot_status[idx] <= nstat_r;
          end
        end
        tts_pkg::OP_DELAY: begin
          if (in_range) begin
            slot_due_time[idx] <= cur_due + 32'(dsec_r);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      reply_kind <= emit_kind;
      slot_index <= emit_index;
      fired_type <= emit_type;
      last       <= emit_last;
    end
  end

endmodule

@@ rtl/core/timed_task_slot_table_top.sv @@
// Top level of the timed task slot table: joins the controller and datapath.
// Depends on tts_pkg, tts_ctrl and tts_datapath.
//
//   channel  handshake               payload
//   in       in_valid / in_ready     op .. delay_seconds
//   out      out_valid / out_ready   reply_kind, slot_index, fired_type, last
//   cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Items are taken one at a time. Add walks the slots in index order and stops
// at the first free slot or at the last slot; a tick always walks all slots,
// one scan step per slot after entry, then a tick-end step. Other ops take one edit step.
// A stalled result register holds the walk until the transfer completes.
// Synchronous reset frees all slots and loads the register defaults at once.
// Both input channels hold ready low while reset is asserted.
module timed_task_slot_table_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  op,
  input  logic [3:0]  slot,
  input  logic [1:0]  job_type,
  input  logic        time_mode,
  input  logic [7:0]  hours,
  input  logic [7:0]  minutes,
  input  logic [31:0] target_time,
  input  logic [31:0] now_time,
  input  logic [2:0]  new_status,
  input  logic [7:0]  delay_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  reply_kind,
  output logic [3:0]  slot_index,
  output logic [1:0]  fired_type,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  tts_pkg::ctrl_t ctrl;
  tts_pkg::stat_t stat;

  assign cfg_ready = !rst;

  tts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  tts_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .stat          (stat),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .op            (op),
    .slot          (slot),
    .job_type      (job_type),
    .time_mode     (time_mode),
    .hours         (hours),
    .minutes       (minutes),
    .target_time   (target_time),
    .now_time      (now_time),
    .new_status    (new_status),
    .delay_seconds (delay_seconds),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .reply_kind    (reply_kind),
    .slot_index    (slot_index),
    .fired_type    (fired_type),
    .last          (last)
  );

endmodule
